>>> design/sroc_pkg.sv
// Shared types and constants for the sector-range claim overlap table.
`default_nettype none
package sroc_pkg;

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_CHECK    = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  localparam logic [4:0] MAX_CONFLICTS_RST = 5'd16;
  localparam logic [4:0] REPORT_CAP        = 5'd16;
  localparam logic [4:0] TOTAL_SAT         = 5'd31;

  // Table update broadcast to every cell on an accepted register or clear.
  typedef struct packed {
    logic        set;
    logic        clr;
    logic [4:0]  slot;
    logic [10:0] part;
    logic [31:0] start;
    logic [31:0] count;
  } wr_t;

  // Check query that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic        excl_en;
    logic [4:0]  slot;
    logic [31:0] start;
    logic [32:0] qend;
    logic        cnt_nz;
    logic [4:0]  limit;
    logic [4:0]  total;
  } tok_t;

  // Conflict entry from one cell; all zero when the cell reports nothing.
  typedef struct packed {
    logic        valid;
    logic [3:0]  slot;
    logic [10:0] part;
  } hit_t;

endpackage
`default_nettype wire

>>> design/sroc_cell.sv
// One table slot: stores a claim and tests the passing check query against it.
`default_nettype none
module sroc_cell
  import sroc_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire wr_t  wr_i,
  input  wire tok_t tok_i,
  output tok_t      tok_o,
  output hit_t      hit_o
);

  logic        valid_r;
  logic [10:0] part_r;
  logic [31:0] start_r;
  logic [32:0] end_r;
  logic        cnt_nz_r;
  tok_t        tok_r, tok_nxt;
  hit_t        hit_r, hit_nxt;
  logic        sel;
  logic        excluded;
  logic        overlap;

  assign sel      = (32'(wr_i.slot) == 32'(CELL_ID));
  assign excluded = tok_i.excl_en && (32'(tok_i.slot) == 32'(CELL_ID));
  assign overlap  = tok_i.valid && valid_r && !excluded && tok_i.cnt_nz && cnt_nz_r &&
                    ({1'b0, tok_i.start} < end_r) && ({1'b0, start_r} < tok_i.qend);

  always_comb begin
    tok_nxt = tok_i;
    hit_nxt = '0;
    if (overlap) begin
      tok_nxt.total = (tok_i.total == TOTAL_SAT) ? TOTAL_SAT : tok_i.total + 5'd1;
      if (tok_i.total < tok_i.limit) begin
        hit_nxt.valid = 1'b1;
        hit_nxt.slot  = 4'(CELL_ID);
        hit_nxt.part  = part_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
      hit_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      hit_r <= hit_nxt;
      if (sel && wr_i.set) begin
        valid_r <= 1'b1;
      end else if (sel && wr_i.clr) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Claim payload; the end is precomputed with 33 bits so it never wraps.
  always_ff @(posedge clk) begin
    if (sel && wr_i.set) begin
      part_r   <= wr_i.part;
      start_r  <= wr_i.start;
      end_r    <= {1'b0, wr_i.start} + {1'b0, wr_i.count};
      cnt_nz_r <= (wr_i.count != 32'd0);
    end
  end

  assign tok_o = tok_r;
  assign hit_o = hit_r;

endmodule
`default_nettype wire

>>> design/sector_range_claim_overlap_table.sv
// Top level of the sector-range claim overlap table.
// A register or clear transaction is acknowledged in the cycle after start is taken and
// the block is idle the cycle after that. A check walks through a chain of SLOTS
// cells, one cell per clock, so conflict entries appear in slot order as the query
// passes each cell, and the summary is registered after the last cell; busy drops
// the cycle after the summary. Results are single-cycle strobes on out_valid and
// cannot be held off, so the receiver must take every one.
`default_nettype none
module sector_range_claim_overlap_table
  import sroc_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [4:0]  in_slot,
  input  wire logic [10:0] in_partition_number,
  input  wire logic [31:0] in_start_sector,
  input  wire logic [31:0] in_sector_count,
  output logic             out_valid,
  output logic             out_kind,
  output logic [3:0]       out_conflict_slot,
  output logic [10:0]      out_conflict_partition,
  output logic [4:0]       out_conflict_total,
  output logic             out_any_conflict,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);

  logic        busy_r;
  logic        ack_r;
  logic        sum_valid_r;
  logic [4:0]  sum_total_r;
  logic [4:0]  max_conf_r;
  tok_t        tok0_r, tok0_nxt;
  wr_t         wr;
  logic        accept;
  logic        is_check;
  tok_t        tok_w [SLOTS+1];
  hit_t        hit_w [SLOTS];
  hit_t        hit_any;
  logic [SLOTS-1:0] hit_vec;

  assign accept   = start && !busy_r;
  assign is_check = (mode_t'(in_mode) == MODE_CHECK);

  always_comb begin
    wr       = '0;
    wr.slot  = in_slot;
    wr.part  = in_partition_number;
    wr.start = in_start_sector;
    wr.count = in_sector_count;
    wr.set   = accept && (mode_t'(in_mode) == MODE_REGISTER);
    wr.clr   = accept && (mode_t'(in_mode) == MODE_CLEAR);
  end

  always_comb begin
    tok0_nxt         = '0;
    tok0_nxt.valid   = accept && is_check;
    tok0_nxt.excl_en = (32'(in_slot) < 32'(SLOTS));
    tok0_nxt.slot    = in_slot;
    tok0_nxt.start   = in_start_sector;
    tok0_nxt.qend    = {1'b0, in_start_sector} + {1'b0, in_sector_count};
    tok0_nxt.cnt_nz  = (in_sector_count != 32'd0);
    tok0_nxt.limit   = (max_conf_r > REPORT_CAP) ? REPORT_CAP : max_conf_r;
    tok0_nxt.total   = 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ack_r       <= 1'b0;
      sum_valid_r <= 1'b0;
      sum_total_r <= 5'd0;
      max_conf_r  <= MAX_CONFLICTS_RST;
      tok0_r      <= '0;
    end else begin
      tok0_r      <= tok0_nxt;
      ack_r       <= accept && !is_check;
      sum_valid_r <= tok_w[SLOTS].valid;
      sum_total_r <= tok_w[SLOTS].total;
      if (cfg_we) begin
        max_conf_r <= cfg_wdata;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (ack_r || sum_valid_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign tok_w[0] = tok0_r;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sroc_cell #(
      .CELL_ID(i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .wr_i (wr),
      .tok_i(tok_w[i]),
      .tok_o(tok_w[i+1]),
      .hit_o(hit_w[i])
    );
    assign hit_vec[i] = hit_w[i].valid;
  end

  // At most one cell holds the query, so the gated cell outputs simply OR together.
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_any = hit_any | hit_w[i];
    end
  end

  assign busy                   = busy_r;
  assign out_valid              = ack_r || sum_valid_r || hit_any.valid;
  assign out_kind               = ack_r || sum_valid_r;
  assign out_last               = ack_r || sum_valid_r;
  assign out_conflict_slot      = hit_any.slot;
  assign out_conflict_partition = hit_any.part;
  assign out_conflict_total     = sum_valid_r ? sum_total_r : 5'd0;
  assign out_any_conflict       = sum_valid_r && (sum_total_r != 5'd0);

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
    else $error("more than one cell reported a conflict in the same cycle");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy_r)
    else $error("result strobe while no transaction is in progress");

  a_sum_alone: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid_r |-> !hit_any.valid && !ack_r)
    else $error("summary collided with another result");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy_r)
    else $error("block stayed busy after the final result");

endmodule
`default_nettype wire
